/* design/ddo_pkg.sv */
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned ITER_W = 5;
  localparam logic [33:0] CORDIC_GAIN = 34'h026DD3B6A;

  localparam logic REG_METERS_PER_TICK = 1'b0;
  localparam logic REG_TURN_PER_TICK = 1'b1;

  localparam logic [31:0] METERS_PER_TICK_RST = 32'd894785;
  localparam logic [31:0] TURN_PER_TICK_RST = 32'd1780118;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_DIST,
    ST_MUL_TURN,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_MUL_X,
    ST_MUL_Y,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MSEL_DIST,
    MSEL_TURN,
    MSEL_X,
    MSEL_Y
  } mul_sel_e;

  typedef struct packed {
    logic              load_in;
    logic              prime;
    logic              latch_sum;
    logic              mul_en;
    mul_sel_e          mul_sel;
    logic              load_dist;
    logic              cordic_init;
    logic              cordic_step;
    logic [ITER_W-1:0] iter;
    logic              load_x;
    logic              load_y;
    logic              commit;
    logic              emit;
  } dp_cmd_t;

  typedef struct packed {
    logic primed;
    logic moved;
  } dp_sts_t;

  function automatic logic [31:0] atan_lookup(input logic [ITER_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'h20000000;
      5'd1:  val = 32'h12E4051E;
      5'd2:  val = 32'h09FB385B;
      5'd3:  val = 32'h051111D4;
      5'd4:  val = 32'h028B0D43;
      5'd5:  val = 32'h0145D7E1;
      5'd6:  val = 32'h00A2F61E;
      5'd7:  val = 32'h00517C55;
      5'd8:  val = 32'h0028BE53;
      5'd9:  val = 32'h00145F2F;
      5'd10: val = 32'h000A2F98;
      5'd11: val = 32'h000517CC;
      5'd12: val = 32'h00028BE6;
      5'd13: val = 32'h000145F3;
      5'd14: val = 32'h0000A2FA;
      5'd15: val = 32'h0000517D;
      5'd16: val = 32'h000028BE;
      5'd17: val = 32'h0000145F;
      5'd18: val = 32'h00000A30;
      5'd19: val = 32'h00000518;
      5'd20: val = 32'h0000028C;
      5'd21: val = 32'h00000146;
      5'd22: val = 32'h000000A3;
      5'd23: val = 32'h00000051;
      5'd24: val = 32'h00000029;
      5'd25: val = 32'h00000014;
      5'd26: val = 32'h0000000A;
      5'd27: val = 32'h00000005;
      5'd28: val = 32'h00000003;
      5'd29: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

/* design/ddo_datapath.sv */
`timescale 1ns / 1ps

module ddo_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic signed [31:0]    left_count_i,
  input  logic signed [31:0]    right_count_i,
  input  logic [62:0]           sample_time_i,
  input  ddo_pkg::dp_cmd_t      cmd_i,
  output ddo_pkg::dp_sts_t      sts_o,
  output logic signed [31:0]    pos_x_o,
  output logic signed [31:0]    pos_y_o,
  output logic [31:0]           heading_o,
  output logic [62:0]           pose_time_o
);

  logic [31:0] meters_q, turn_q;
  logic        primed_q;
  logic [31:0] last_left_q, last_right_q;
  logic [31:0] cur_x_q, cur_y_q, cur_heading_q;

  logic [31:0] left_q, right_q;
  logic [62:0] time_q;

  logic [32:0] smag_q;
  logic        sneg_q;
  logic [32:0] diff_q;
  logic [65:0] prod_q;
  logic [31:0] dist_q;
  logic [31:0] t_q;
  logic        flip_q;
  logic signed [33:0] x_q, y_q, z_q;

  logic [31:0] dl, dr;
  logic [32:0] sum, smag_d, diff_d;
  logic [32:0] mul_a, mul_b;
  logic [65:0] dist_rnd;
  logic [31:0] dist_d;
  logic [31:0] mid;
  logic [31:0] ang;
  logic signed [33:0] xs, ys, atan_v;
  logic signed [33:0] cx, cy;
  logic [32:0] tmag_x, tmag_y;

  function automatic logic [31:0] advance(input logic [31:0] pos, input logic [65:0] prod,
                                          input logic neg);
    logic [65:0] rnd;
    logic [37:0] mag;
    logic [37:0] r;
    rnd = prod + (66'(1) << 29);
    mag = {2'b00, rnd[65:30]};
    if (neg) begin
      r = {{6{pos[31]}}, pos} - mag;
    end else begin
      r = {{6{pos[31]}}, pos} + mag;
    end
    if (r[37] && (r[36:31] != 6'h3F)) begin
      return 32'h80000000;
    end else if (!r[37] && (r[36:31] != 6'h00)) begin
      return 32'h7FFFFFFF;
    end
    return r[31:0];
  endfunction

  assign dl = left_q - last_left_q;
  assign dr = right_q - last_right_q;
  assign sum = {dl[31], dl} + {dr[31], dr};
  assign smag_d = sum[32] ? (33'd0 - sum) : sum;
  assign diff_d = {dr[31], dr} - {dl[31], dl};

  assign sts_o.primed = primed_q;
  assign sts_o.moved = (left_q != last_left_q) || (right_q != last_right_q);

  assign cx = flip_q ? -x_q : x_q;
  assign cy = flip_q ? -y_q : y_q;
  assign tmag_x = cx[33] ? 33'(-cx) : 33'(cx);
  assign tmag_y = cy[33] ? 33'(-cy) : 33'(cy);

  always_comb begin
    case (cmd_i.mul_sel)
      ddo_pkg::MSEL_DIST: begin
        mul_a = smag_q;
        mul_b = {1'b0, meters_q};
      end
      ddo_pkg::MSEL_TURN: begin
        mul_a = diff_q;
        mul_b = {1'b0, turn_q};
      end
      ddo_pkg::MSEL_X: begin
        mul_a = {1'b0, dist_q};
        mul_b = tmag_x;
      end
      ddo_pkg::MSEL_Y: begin
        mul_a = {1'b0, dist_q};
        mul_b = tmag_y;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dist_rnd = prod_q + 66'd65536;
  assign dist_d = (dist_rnd[65:49] != 17'd0) ? 32'hFFFFFFFF : dist_rnd[48:17];

  assign mid = cur_heading_q + prod_q[32:1];
  assign ang = {mid[31] ^ (mid[31] ^ mid[30]), mid[30:0]};

  assign xs = x_q >>> cmd_i.iter;
  assign ys = y_q >>> cmd_i.iter;
  assign atan_v = {2'b00, ddo_pkg::atan_lookup(cmd_i.iter)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meters_q <= ddo_pkg::METERS_PER_TICK_RST;
      turn_q <= ddo_pkg::TURN_PER_TICK_RST;
      primed_q <= 1'b0;
      last_left_q <= '0;
      last_right_q <= '0;
      cur_x_q <= '0;
      cur_y_q <= '0;
      cur_heading_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == ddo_pkg::REG_METERS_PER_TICK) begin
          meters_q <= cfg_wdata_i;
        end else begin
          turn_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.prime || cmd_i.commit) begin
        last_left_q <= left_q;
        last_right_q <= right_q;
      end
      if (cmd_i.prime) begin
        primed_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        cur_heading_q <= cur_heading_q + t_q;
      end
      if (cmd_i.load_x) begin
        cur_x_q <= advance(cur_x_q, prod_q, sneg_q ^ cx[33]);
      end
      if (cmd_i.load_y) begin
        cur_y_q <= advance(cur_y_q, prod_q, sneg_q ^ cy[33]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_q <= left_count_i;
      right_q <= right_count_i;
      time_q <= sample_time_i;
    end
    if (cmd_i.latch_sum) begin
      smag_q <= smag_d;
      sneg_q <= sum[32];
      diff_q <= diff_d;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.load_dist) begin
      dist_q <= dist_d;
    end
    if (cmd_i.cordic_init) begin
      t_q <= prod_q[31:0];
      flip_q <= mid[31] ^ mid[30];
      x_q <= ddo_pkg::CORDIC_GAIN;
      y_q <= '0;
      z_q <= {{2{ang[31]}}, ang};
    end else if (cmd_i.cordic_step) begin
      if (!z_q[33]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end
    end
    if (cmd_i.emit) begin
      pos_x_o <= cur_x_q;
      pos_y_o <= cur_y_q;
      heading_o <= cur_heading_q;
      pose_time_o <= time_q;
    end
  end

endmodule

/* design/ddo_controller.sv */
`timescale 1ns / 1ps

module ddo_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ddo_pkg::dp_sts_t sts_i,
  output ddo_pkg::dp_cmd_t cmd_o
);

  ddo_pkg::state_e state_q, state_d;
  logic [ddo_pkg::ITER_W-1:0] iter_q, iter_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ddo_pkg::ST_IDLE;
      iter_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.mul_sel = ddo_pkg::MSEL_DIST;
    cmd_o.iter = iter_q;
    case (state_q)
      ddo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ddo_pkg::ST_CHECK;
        end
      end
      ddo_pkg::ST_CHECK: begin
        if (!sts_i.primed) begin
          cmd_o.prime = 1'b1;
          state_d = ddo_pkg::ST_IDLE;
        end else if (!sts_i.moved) begin
          state_d = ddo_pkg::ST_EMIT;
        end else begin
          cmd_o.latch_sum = 1'b1;
          state_d = ddo_pkg::ST_MUL_DIST;
        end
      end
      ddo_pkg::ST_MUL_DIST: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = ddo_pkg::MSEL_DIST;
        state_d = ddo_pkg::ST_MUL_TURN;
      end
      ddo_pkg::ST_MUL_TURN: begin
        cmd_o.load_dist = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = ddo_pkg::MSEL_TURN;
        state_d = ddo_pkg::ST_CORDIC_INIT;
      end
      ddo_pkg::ST_CORDIC_INIT: begin
        cmd_o.cordic_init = 1'b1;
        iter_d = '0;
        state_d = ddo_pkg::ST_CORDIC;
      end
      ddo_pkg::ST_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (iter_q == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_ITERS - 1)) begin
          iter_d = '0;
          state_d = ddo_pkg::ST_MUL_X;
        end else begin
          iter_d = iter_q + 1'b1;
        end
      end
      ddo_pkg::ST_MUL_X: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = ddo_pkg::MSEL_X;
        state_d = ddo_pkg::ST_MUL_Y;
      end
      ddo_pkg::ST_MUL_Y: begin
        cmd_o.load_x = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_sel = ddo_pkg::MSEL_Y;
        state_d = ddo_pkg::ST_UPDATE;
      end
      ddo_pkg::ST_UPDATE: begin
        cmd_o.load_y = 1'b1;
        cmd_o.commit = 1'b1;
        state_d = ddo_pkg::ST_EMIT;
      end
      ddo_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          out_valid_d = 1'b1;
          state_d = ddo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddo_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/differential_drive_odometry.sv */
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// config    cfg_we_i                  cfg_index_i, cfg_wdata_i
// sample    in_valid_i / in_ready_o   left_count_i, right_count_i, sample_time_i
// pose      out_valid_o / out_ready_i pos_x_o, pos_y_o, heading_o, pose_time_o
//
// A moving sample passes through the 30 steps of the CORDIC rotator and four
// passes through the one multiplier on its way from acceptance to pose.
// A sample with no wheel motion goes from the check state straight to its pose;
// the priming sample gives no pose.
// Reset clears the pose and count history and loads the default gains.
// A new sample is accepted while a finished pose waits in the output register;
// the next pose waits in the sequencer until that register is free.

module differential_drive_odometry (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  left_count_i,
  input  logic signed [31:0]  right_count_i,
  input  logic [62:0]         sample_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic [31:0]         heading_o,
  output logic [62:0]         pose_time_o
);

  ddo_pkg::dp_cmd_t cmd;
  ddo_pkg::dp_sts_t sts;

  ddo_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ddo_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .left_count_i (left_count_i),
    .right_count_i(right_count_i),
    .sample_time_i(sample_time_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .heading_o    (heading_o),
    .pose_time_o  (pose_time_o)
  );

endmodule

/* design/ddo_checker.sv */
`timescale 1ns / 1ps

module ddo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] pos_x_o,
  input logic [31:0] pos_y_o,
  input logic [31:0] heading_o,
  input logic [62:0] pose_time_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("pose transaction dropped before acceptance");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pos_x_o) && $stable(pos_y_o)
      && $stable(heading_o) && $stable(pose_time_o))
    else $error("stalled pose payload changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sample accepted while previous one is in progress");

  a_no_early_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("pose appeared in the cycle after a sample transaction");

  a_ready_with_pose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sequencer not idle after issuing a pose");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .pos_x_o    (pos_x_o),
  .pos_y_o    (pos_y_o),
  .heading_o  (heading_o),
  .pose_time_o(pose_time_o)
);
